// File: rtl/assert_macros.svh
// Assertion macros shared by the fragment check-word RTL.
// Depends on a clock named clk and a reset named rst in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every edge outside reset.
`define PFM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check on every edge, reset included.
`define PFM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: rtl/pfm_pkg.sv
// Shared constants, result type and byte-wise CRC-32 update for the
// fragment check-word block. No dependencies.
`default_nettype none

package pfm_pkg;

  localparam logic [31:0] CrcPoly    = 32'hEDB8_8320;
  localparam logic [31:0] CrcInit    = 32'hFFFF_FFFF;
  localparam logic [31:0] McrcMask   = 32'hFFFF_0000;
  localparam int          ByteBits   = 8;

  typedef struct packed {
    logic [31:0] check_word;
    logic        mcrc_flag;
  } pfm_result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0]  data);
    logic [31:0] crc;
    crc = crc_in ^ {24'd0, data};
    for (int i = 0; i < ByteBits; i++) begin
      crc = crc[0] ? ((crc >> 1) ^ CrcPoly) : (crc >> 1);
    end
    return crc;
  endfunction

endpackage

`default_nettype wire

// File: rtl/pfm_byte_if.sv
// Valid/ready channel interfaces for fragment bytes and check-word results.
// Depends on nothing.
`default_nettype none

interface pfm_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_fragment;
  logic       last_fragment;
  logic       fragment_end;

  modport source (output valid, data_byte, first_fragment, last_fragment, fragment_end,
                  input ready);
  modport sink   (input valid, data_byte, first_fragment, last_fragment, fragment_end,
                  output ready);
endinterface

interface pfm_check_if;
  logic        valid;
  logic        ready;
  logic [31:0] check_word;
  logic        mcrc_flag;

  modport source (output valid, check_word, mcrc_flag, input ready);
  modport sink   (input valid, check_word, mcrc_flag, output ready);
endinterface

`default_nettype wire

// File: rtl/pfm_crc_core.sv
// Frame and fragment CRC-32 state with the check-word selection for one beat.
// Depends on pfm_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module pfm_crc_core (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic [7:0]         data_byte,
  input  wire logic               first_fragment,
  input  wire logic               last_fragment,
  input  wire logic               fragment_end,
  output pfm_pkg::pfm_result_t    res
);
  import pfm_pkg::*;

  logic [31:0] frame_crc;
  logic [31:0] frag_crc;
  logic        at_start;
  logic [31:0] frame_base;
  logic [31:0] frag_base;
  logic [31:0] frame_crc_next;
  logic [31:0] frag_crc_next;

  always_comb begin
    frame_base     = (at_start && first_fragment) ? CrcInit : frame_crc;
    frag_base      = at_start ? CrcInit : frag_crc;
    frame_crc_next = crc_byte(frame_base, data_byte);
    frag_crc_next  = crc_byte(frag_base, data_byte);
    if (last_fragment) begin
      res.check_word = ~frame_crc_next;
      res.mcrc_flag  = 1'b0;
    end else begin
      res.check_word = ~frag_crc_next ^ McrcMask;
      res.mcrc_flag  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_crc <= CrcInit;
      frag_crc  <= CrcInit;
      at_start  <= 1'b1;
    end else if (accept) begin
      frame_crc <= frame_crc_next;
      frag_crc  <= frag_crc_next;
      at_start  <= fragment_end;
    end
  end

  `PFM_ASSERT(a_start_follows_end, accept |=> (at_start == $past(fragment_end)), "start flag")
  `PFM_ASSERT(a_state_holds_idle, !accept |=> ($stable(frame_crc) && $stable(frag_crc)), "CRC moved")
  `PFM_ASSERT_ALWAYS(a_reset_state, rst |=> (at_start && frame_crc == CrcInit), "reset state")

endmodule

`default_nettype wire

// File: rtl/preemption_fragment_mcrc.sv
// Fragment check-word generator: one byte beat per cycle while the skid entry is empty.
// A fragment's final byte registers its check word in the output or skid entry.
// Output register plus one skid entry; input stalls only when both are full.
// Synchronous active-high reset: CRC state all ones, at fragment start, no results held.
`default_nettype none
`include "assert_macros.svh"

module preemption_fragment_mcrc (
  input  wire logic     clk,
  input  wire logic     rst,
  pfm_byte_if.sink      frag_bytes,
  pfm_check_if.source   checks
);
  import pfm_pkg::*;

  pfm_result_t core_res;
  pfm_result_t out_data;
  pfm_result_t skid_data;
  logic        out_valid;
  logic        skid_valid;
  logic        accept;
  logic        push;
  logic        pop;

  assign frag_bytes.ready = !skid_valid;
  assign accept           = frag_bytes.valid && frag_bytes.ready;
  assign push             = accept && frag_bytes.fragment_end;
  assign pop              = out_valid && checks.ready;

  pfm_crc_core u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .data_byte      (frag_bytes.data_byte),
    .first_fragment (frag_bytes.first_fragment),
    .last_fragment  (frag_bytes.last_fragment),
    .fragment_end   (frag_bytes.fragment_end),
    .res            (core_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || pop) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || pop) begin
      out_data <= skid_valid ? skid_data : core_res;
    end else if (push) begin
      skid_data <= core_res;
    end
  end

  assign checks.valid      = out_valid;
  assign checks.check_word = out_data.check_word;
  assign checks.mcrc_flag  = out_data.mcrc_flag;

  `PFM_ASSERT(a_skid_behind_out, !skid_valid || out_valid, "skid entry held with empty output")
  `PFM_ASSERT(a_stall_fills_skid, (out_valid && !checks.ready && push) |=> skid_valid, "lost")
  `PFM_ASSERT(a_skid_drains, (skid_valid && checks.ready) |=> (!skid_valid && out_valid), "stuck")

endmodule

`default_nettype wire

// File: verif/preemption_fragment_mcrc_tb.sv
// Testbench for preemption_fragment_mcrc: sends fragment byte beats, predicts the
// FCS or mCRC of each fragment and checks every check-word beat in order.
// Depends on pfm_pkg, pfm_byte_if, pfm_check_if and the block's RTL.
module preemption_fragment_mcrc_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfm_pkg::*;

  localparam int CycleLimit  = 200000;
  localparam int MaxReported = 10;
  localparam int DrainCycles = 8;
  localparam int HoldOff     = 300;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #1ns clk = 1'b1;
    #1ns clk = 1'b0;
  end

  pfm_byte_if  byte_ch ();
  pfm_check_if check_ch ();

  preemption_fragment_mcrc dut (
    .clk        (clk),
    .rst        (rst),
    .frag_bytes (byte_ch),
    .checks     (check_ch)
  );

  logic [31:0] frame_crc;
  logic [31:0] frag_crc;
  logic        fresh_fragment;
  pfm_result_t pending_checks[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_cycles   = 0;
  int cycles        = 0;
  int mismatches    = 0;
  int beats_sent    = 0;
  int checks_seen   = 0;
  int mcrc_seen     = 0;
  int fcs_seen      = 0;

  function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] data);
    logic [31:0] c;
    logic        fb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ data[i];
      c  = {1'b0, c[31:1]} ^ (fb ? CrcPoly : 32'd0);
    end
    return c;
  endfunction

  function automatic void fold_byte(input logic [7:0] d, input logic f, input logic l,
                                    input logic e);
    pfm_result_t r;
    if (fresh_fragment) begin
      frag_crc = CrcInit;
      if (f) frame_crc = CrcInit;
    end
    frame_crc      = crc32_step(frame_crc, d);
    frag_crc       = crc32_step(frag_crc, d);
    fresh_fragment = e;
    if (e) begin
      r.mcrc_flag  = !l;
      r.check_word = l ? ~frame_crc : (~frag_crc ^ McrcMask);
      pending_checks.push_back(r);
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MaxReported) $display("mismatch at cycle %0d: %s", cycles, msg);
  endfunction

  task automatic send_byte(input logic [7:0] d, input logic f, input logic l, input logic e);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      byte_ch.valid <= 1'b0;
      @(posedge clk);
    end
    byte_ch.valid          <= 1'b1;
    byte_ch.data_byte      <= d;
    byte_ch.first_fragment <= f;
    byte_ch.last_fragment  <= l;
    byte_ch.fragment_end   <= e;
    do @(posedge clk); while (!byte_ch.ready);
    fold_byte(d, f, l, e);
    beats_sent++;
  endtask

  task automatic wait_drained();
    byte_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_checks.size() != 0);
  endtask

  // Flags off the sampled positions are random noise.
  task automatic send_frame(input int nfrag);
    int len;
    for (int k = 0; k < nfrag; k++) begin
      len = ($urandom_range(19, 0) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
      for (int i = 0; i < len; i++) begin
        send_byte(8'($urandom_range(255, 0)),
                  (i == 0) ? (k == 0) : 1'($urandom_range(1, 0)),
                  (i == len - 1) ? (k == nfrag - 1) : 1'($urandom_range(1, 0)),
                  i == len - 1);
      end
    end
  endtask

  task automatic test_directed();
    send_byte(8'h00, 1'b0, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0, 1'b1);
    send_byte(8'h00, 1'b1, 1'b1, 1'b1);
    send_byte(8'hFF, 1'b1, 1'b0, 1'b1);
    send_byte(8'hA5, 1'b0, 1'b1, 1'b1);
    send_byte(8'h5A, 1'b0, 1'b0, 1'b0);
    send_byte(8'h3C, 1'b0, 1'b1, 1'b1);
    send_byte(8'h11, 1'b1, 1'b1, 1'b0);
    send_byte(8'h22, 1'b0, 1'b1, 1'b0);
    send_byte(8'h33, 1'b0, 1'b0, 1'b1);
    send_byte(8'h44, 1'b0, 1'b0, 1'b0);
    send_byte(8'h55, 1'b1, 1'b0, 1'b0);
    send_byte(8'h66, 1'b1, 1'b0, 1'b1);
    send_byte(8'h77, 1'b0, 1'b0, 1'b0);
    send_byte(8'h88, 1'b0, 1'b0, 1'b0);
    send_byte(8'h99, 1'b0, 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int n_beats, input int sender_pct,
                                     input int receiver_pct);
    int stop_at;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    stop_at       = beats_sent + n_beats;
    while (beats_sent < stop_at) begin
      if ($urandom_range(99, 0) < 85) begin
        send_frame($urandom_range(4, 1));
      end else begin
        repeat ($urandom_range(8, 1))
          send_byte(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)),
                    1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)));
      end
    end
    wait_drained();
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req++;
    repeat (40)
      send_byte(8'($urandom_range(255, 0)), 1'($urandom_range(1, 0)),
                1'($urandom_range(1, 0)), 1'b1);
    wait_drained();
  endtask

  task automatic test_pause_between_frames();
    send_idle_pct = 10;
    recv_idle_pct = 10;
    repeat (5) begin
      send_frame($urandom_range(3, 1));
      wait_drained();
    end
  endtask

  // Receiver: random stalls, or a long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      check_ch.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen      = hold_req;
      hold_cycles    = HoldOff;
      check_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      check_ch.ready <= 1'b0;
      hold_cycles--;
    end else begin
      check_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    pfm_result_t want;
    if (!rst && check_ch.valid && check_ch.ready) begin
      checks_seen++;
      if (check_ch.mcrc_flag) mcrc_seen++;
      else fcs_seen++;
      if (pending_checks.size() == 0) begin
        note_mismatch($sformatf("unexpected beat check_word=%08h mcrc_flag=%0b",
                                check_ch.check_word, check_ch.mcrc_flag));
      end else begin
        want = pending_checks.pop_front();
        if (check_ch.check_word !== want.check_word || check_ch.mcrc_flag !== want.mcrc_flag)
          note_mismatch($sformatf("check_word exp %08h got %08h, mcrc_flag exp %0b got %0b",
                                  want.check_word, check_ch.check_word,
                                  want.mcrc_flag, check_ch.mcrc_flag));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d check words outstanding",
               cycles, pending_checks.size());
      $display("preemption_fragment_mcrc_tb: done, errors");
      $finish;
    end
  end

  initial begin
    byte_ch.valid          = 1'b0;
    byte_ch.data_byte      = 8'h00;
    byte_ch.first_fragment = 1'b0;
    byte_ch.last_fragment  = 1'b0;
    byte_ch.fragment_end   = 1'b0;
    frame_crc              = CrcInit;
    frag_crc               = CrcInit;
    fresh_fragment         = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_traffic(320, 32, 70);
    test_random_traffic(320, 70, 32);
    test_random_traffic(320, 0, 0);
    test_output_backpressure();
    test_pause_between_frames();

    wait_drained();
    repeat (DrainCycles) @(posedge clk);

    $display("sent %0d byte beats; checked %0d check words (%0d mCRC, %0d FCS)",
             beats_sent, checks_seen, mcrc_seen, fcs_seen);
    $display("covered flag noise, single-byte fragments, unflagged continuation, long stalls");
    if (mismatches == 0) begin
      $display("preemption_fragment_mcrc_tb: done, clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("preemption_fragment_mcrc_tb: done, errors");
    end
    $finish;
  end

endmodule
